// ===== sv/rtq_pkg.sv =====
`default_nettype none

package rtq_pkg;

    // Converter resolution and derived limits.
    localparam int ADC_BITS = 12;
    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

    // Widths of the pressure sum, the scaled positions, the product and the step counter.
    localparam int PRES_W = ADC_BITS + 1;
    localparam int POS_W = 13;
    localparam int PROD_W = 2 * ADC_BITS;
    localparam int CNT_W = $clog2(ADC_BITS);

    // Position code used when no coordinate is known (-1).
    localparam logic signed [POS_W-1:0] NONE_POS = '1;

    // Configuration register indexes.
    localparam logic [2:0] REG_ARMED = 3'd0;
    localparam logic [2:0] REG_IRQ_USED = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_CAL_MIN = 3'd3;
    localparam logic [2:0] REG_CAL_MAX = 3'd4;
    localparam logic [2:0] REG_OUT_MAX = 3'd5;

    // Register reset values.
    localparam logic RST_ARMED = 1'b0;
    localparam logic RST_IRQ_USED = 1'b1;
    localparam logic [PRES_W-1:0] RST_THRESHOLD = 13'd400;
    localparam logic [ADC_BITS-1:0] RST_CAL_MIN = 12'd300;
    localparam logic [ADC_BITS-1:0] RST_CAL_MAX = 12'd3800;
    localparam logic [ADC_BITS-1:0] RST_OUT_MAX = 12'd239;

    // Input item opcodes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== sv/rtq_in_if.sv =====
`default_nettype none

interface rtq_in_if;
    logic valid;
    logic ready;
    logic opcode;
    logic irq_released;
    logic [rtq_pkg::ADC_BITS-1:0] z1_raw;
    logic [rtq_pkg::ADC_BITS-1:0] z2_raw;
    logic [rtq_pkg::ADC_BITS-1:0] x_raw;
    logic [rtq_pkg::ADC_BITS-1:0] y_raw;

    modport source (
        output valid, opcode, irq_released, z1_raw, z2_raw, x_raw, y_raw,
        input ready
    );
    modport sink (
        input valid, opcode, irq_released, z1_raw, z2_raw, x_raw, y_raw,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/rtq_out_if.sv =====
`default_nettype none

interface rtq_out_if;
    logic valid;
    logic ready;
    logic flag;
    logic signed [rtq_pkg::POS_W-1:0] x_pos;
    logic signed [rtq_pkg::POS_W-1:0] y_pos;

    modport source (
        output valid, flag, x_pos, y_pos,
        input ready
    );
    modport sink (
        input valid, flag, x_pos, y_pos,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/resistive_touch_qualifier.sv =====
// Resistive touch-panel qualifier.
// Input channel i_in carries one item per handshake: a touch sample (Z1, Z2,
// X, Y conversions and the pen-interrupt level) or a request to consume the
// latched tap. Every item yields exactly one result item on o_out: the
// pressed/tap flag and the scaled X and Y positions (-1 when none known).
// Registers are to be written through the APB port only while the block is
// idle; the block itself does not enforce this. Consume requests, release
// samples and samples taken while not armed go from idle straight to the
// done state and then into the output register. A pressed sample runs one
// multiply state and twelve restoring-division steps for X, the same for Y,
// all on one shared multiplier and divider, then the done state and the
// output register. i_in is ready only while the sequencer is idle, so a new
// item waits until the last result has moved into the output register.
// The result waits in the output register while the receiver stalls; the
// next item is still accepted and finishes up to the output stage.
// A synchronous low reset clears the sequencer, empties the output register,
// forgets any touch and loads the register defaults (block not armed).
`default_nettype none

module resistive_touch_qualifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rtq_in_if.sink           i_in,
    rtq_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = rtq_pkg::ADC_BITS;
    localparam int PW = rtq_pkg::POS_W;

    // Configuration registers.
    logic            r_armed;
    logic            r_irq_used;
    logic [AW:0]     r_threshold;
    logic [AW-1:0]   r_cal_min;
    logic [AW-1:0]   r_cal_max;
    logic [AW-1:0]   r_out_max;

    // Touch state.
    logic                 r_pressed, n_pressed;
    logic                 r_tap, n_tap;
    logic signed [PW-1:0] r_last_x, n_last_x;
    logic signed [PW-1:0] r_last_y, n_last_y;

    // Sequencer and datapath registers.
    rtq_pkg::t_state         r_state, n_state;
    logic                    r_sel_y, n_sel_y;
    logic [rtq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [AW-1:0]           r_x_raw, n_x_raw;
    logic [AW-1:0]           r_y_raw, n_y_raw;
    logic [AW-1:0]           r_rem, n_rem;
    logic [AW-1:0]           r_shift, n_shift;
    logic [AW-1:0]           r_den, n_den;
    logic                    r_res_flag, n_res_flag;
    logic signed [PW-1:0]    r_res_x, n_res_x;
    logic signed [PW-1:0]    r_res_y, n_res_y;

    // Output register.
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_flag;
    logic signed [PW-1:0]    r_out_x;
    logic signed [PW-1:0]    r_out_y;

    // Datapath signals.
    logic                    cfg_wr;
    logic                    in_acc;
    logic                    out_free;
    logic [AW:0]             pressure;
    logic                    released;
    logic                    win_empty;
    logic [AW-1:0]           raw_sel;
    logic [AW-1:0]           raw_clamp;
    logic [AW-1:0]           diff;
    logic [rtq_pkg::PROD_W-1:0] product;
    logic [AW:0]             rem_try;
    logic                    q_bit;
    logic [AW-1:0]           quot;
    logic [AW-1:0]           coord;

    // APB access: writes complete in the access phase, reads are mux-based.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        prdata = '0;
        case (paddr[4:2])
            rtq_pkg::REG_ARMED:     prdata = {31'd0, r_armed};
            rtq_pkg::REG_IRQ_USED:  prdata = {31'd0, r_irq_used};
            rtq_pkg::REG_THRESHOLD: prdata = 32'(r_threshold);
            rtq_pkg::REG_CAL_MIN:   prdata = 32'(r_cal_min);
            rtq_pkg::REG_CAL_MAX:   prdata = 32'(r_cal_max);
            rtq_pkg::REG_OUT_MAX:   prdata = 32'(r_out_max);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= rtq_pkg::RST_ARMED;
            r_irq_used  <= rtq_pkg::RST_IRQ_USED;
            r_threshold <= rtq_pkg::RST_THRESHOLD;
            r_cal_min   <= rtq_pkg::RST_CAL_MIN;
            r_cal_max   <= rtq_pkg::RST_CAL_MAX;
            r_out_max   <= rtq_pkg::RST_OUT_MAX;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                rtq_pkg::REG_ARMED:     r_armed <= pwdata[0];
                rtq_pkg::REG_IRQ_USED:  r_irq_used <= pwdata[0];
                rtq_pkg::REG_THRESHOLD: r_threshold <= pwdata[AW:0];
                rtq_pkg::REG_CAL_MIN:   r_cal_min <= pwdata[AW-1:0];
                rtq_pkg::REG_CAL_MAX:   r_cal_max <= pwdata[AW-1:0];
                rtq_pkg::REG_OUT_MAX:   r_out_max <= pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    // Handshakes.
    assign i_in.ready = (r_state == rtq_pkg::S_IDLE);
    assign in_acc = i_in.valid & i_in.ready;
    assign out_free = ~r_out_valid | o_out.ready;

    // Pressure check: z1 + full scale - z2 never goes negative.
    assign pressure = {1'b0, i_in.z1_raw} + {1'b0, rtq_pkg::ADC_MAX} - {1'b0, i_in.z2_raw};
    assign released = (r_irq_used & i_in.irq_released) | (pressure < r_threshold);

    // Clamp to the calibration window and multiply by the output range.
    assign win_empty = (r_cal_max <= r_cal_min);
    assign raw_sel = r_sel_y ? r_y_raw : r_x_raw;

    always_comb begin
        raw_clamp = raw_sel;
        if (raw_sel < r_cal_min) begin
            raw_clamp = r_cal_min;
        end
        if (raw_sel > r_cal_max) begin
            raw_clamp = r_cal_max;
        end
    end

    assign diff = raw_clamp - r_cal_min;
    assign product = diff * r_out_max;

    // One restoring-division step; the quotient shifts in behind the dividend.
    assign rem_try = {r_rem, r_shift[AW-1]};
    assign q_bit = (rem_try >= {1'b0, r_den});
    assign quot = {r_shift[AW-2:0], q_bit};

    always_comb begin
        coord = quot;
        if (win_empty) begin
            coord = '0;
        end else if (quot > r_out_max) begin
            coord = r_out_max;
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_pressed   = r_pressed;
        n_tap       = r_tap;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_sel_y     = r_sel_y;
        n_cnt       = r_cnt;
        n_x_raw     = r_x_raw;
        n_y_raw     = r_y_raw;
        n_rem       = r_rem;
        n_shift     = r_shift;
        n_den       = r_den;
        n_res_flag  = r_res_flag;
        n_res_x     = r_res_x;
        n_res_y     = r_res_y;
        n_out_valid = r_out_valid & ~o_out.ready;

        case (r_state)
            rtq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_x_raw = i_in.x_raw;
                    n_y_raw = i_in.y_raw;
                    n_state = rtq_pkg::S_DONE;
                    if (i_in.opcode == rtq_pkg::OP_CONSUME) begin
                        n_res_flag = r_tap;
                        n_res_x    = r_last_x;
                        n_res_y    = r_last_y;
                        n_tap      = 1'b0;
                    end else if (!r_armed) begin
                        n_res_flag = 1'b0;
                        n_res_x    = rtq_pkg::NONE_POS;
                        n_res_y    = rtq_pkg::NONE_POS;
                    end else if (released) begin
                        if (r_pressed) begin
                            n_tap     = 1'b1;
                            n_pressed = 1'b0;
                        end
                        n_res_flag = 1'b0;
                        n_res_x    = r_last_x;
                        n_res_y    = r_last_y;
                    end else begin
                        n_sel_y = 1'b0;
                        n_state = rtq_pkg::S_MUL;
                    end
                end
            end
            rtq_pkg::S_MUL: begin
                n_rem   = product[rtq_pkg::PROD_W-1:AW];
                n_shift = product[AW-1:0];
                n_den   = r_cal_max - r_cal_min;
                n_cnt   = '0;
                n_state = rtq_pkg::S_DIV;
            end
            rtq_pkg::S_DIV: begin
                n_rem   = q_bit ? AW'(rem_try - {1'b0, r_den}) : rem_try[AW-1:0];
                n_shift = quot;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == rtq_pkg::CNT_W'(AW - 1)) begin
                    if (!r_sel_y) begin
                        n_last_x = PW'(coord);
                        n_sel_y  = 1'b1;
                        n_state  = rtq_pkg::S_MUL;
                    end else begin
                        n_last_y   = PW'(coord);
                        n_pressed  = 1'b1;
                        n_res_flag = 1'b1;
                        n_res_x    = r_last_x;
                        n_res_y    = PW'(coord);
                        n_state    = rtq_pkg::S_DONE;
                    end
                end
            end
            rtq_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = rtq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rtq_pkg::S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtq_pkg::S_IDLE;
            r_pressed   <= 1'b0;
            r_tap       <= 1'b0;
            r_last_x    <= rtq_pkg::NONE_POS;
            r_last_y    <= rtq_pkg::NONE_POS;
            r_out_valid <= 1'b0;
            r_sel_y     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_pressed   <= n_pressed;
            r_tap       <= n_tap;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_out_valid <= n_out_valid;
            r_sel_y     <= n_sel_y;
            r_cnt       <= n_cnt;
        end
    end

    // Datapath and payload registers.
    always_ff @(posedge i_clk) begin
        r_x_raw    <= n_x_raw;
        r_y_raw    <= n_y_raw;
        r_rem      <= n_rem;
        r_shift    <= n_shift;
        r_den      <= n_den;
        r_res_flag <= n_res_flag;
        r_res_x    <= n_res_x;
        r_res_y    <= n_res_y;
        if (r_state == rtq_pkg::S_DONE && out_free) begin
            r_out_flag <= r_res_flag;
            r_out_x    <= r_res_x;
            r_out_y    <= r_res_y;
        end
    end

    // Result channel.
    assign o_out.valid = r_out_valid;
    assign o_out.flag  = r_out_flag;
    assign o_out.x_pos = r_out_x;
    assign o_out.y_pos = r_out_y;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF = 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRESSURE = 8190;
    localparam int AW = rtq_pkg::ADC_BITS;
    localparam int PW = rtq_pkg::POS_W;
    localparam int PRW = rtq_pkg::PRES_W;

    // One item on the input channel and one on the output channel.
    typedef struct packed {
        logic          opcode;
        logic          irq_released;
        logic [AW-1:0] z1_raw;
        logic [AW-1:0] z2_raw;
        logic [AW-1:0] x_raw;
        logic [AW-1:0] y_raw;
    } t_touch_item;

    typedef struct packed {
        logic                 flag;
        logic signed [PW-1:0] x_pos;
        logic signed [PW-1:0] y_pos;
    } t_touch_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rtq_in_if  in_if ();
    rtq_out_if out_if ();

    resistive_touch_qualifier u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the register file.
    logic           cfg_armed;
    logic           cfg_irq_used;
    logic [PRW-1:0] cfg_threshold;
    logic [AW-1:0]  cfg_cal_min;
    logic [AW-1:0]  cfg_cal_max;
    logic [AW-1:0]  cfg_out_max;

    // Shadow copy of the touch state.
    logic                 panel_pressed;
    logic                 tap_latched;
    logic signed [PW-1:0] last_x;
    logic signed [PW-1:0] last_y;

    t_touch_report pending_reports[$];
    int            error_count;
    int            sink_hold_req;
    int            sink_gap;
    bit            sink_steady;
    bit            src_steady;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Clamp a raw reading to the calibration window and scale it to 0..out_max.
    function automatic logic signed [PW-1:0] scale_pos(logic [AW-1:0] raw);
        int unsigned lo;
        int unsigned hi;
        int unsigned pos;
        int unsigned scaled;
        lo = cfg_cal_min;
        hi = cfg_cal_max;
        if (hi <= lo) begin
            return '0;
        end
        pos = raw;
        if (pos < lo) pos = lo;
        if (pos > hi) pos = hi;
        scaled = (pos - lo) * cfg_out_max / (hi - lo);
        if (scaled > cfg_out_max) scaled = cfg_out_max;
        return scaled[PW-1:0];
    endfunction

    // Work out the report for one accepted item and advance the touch state.
    function automatic t_touch_report predict_report(t_touch_item item);
        t_touch_report report;
        int            pressure;
        if (item.opcode == rtq_pkg::OP_CONSUME) begin
            report = '{tap_latched, last_x, last_y};
            tap_latched = 1'b0;
            return report;
        end
        if (!cfg_armed) begin
            return '{1'b0, rtq_pkg::NONE_POS, rtq_pkg::NONE_POS};
        end
        pressure = int'(item.z1_raw) + int'(rtq_pkg::ADC_MAX) - int'(item.z2_raw);
        if ((cfg_irq_used && item.irq_released) || pressure < int'(cfg_threshold)) begin
            if (panel_pressed) begin
                tap_latched = 1'b1;
                panel_pressed = 1'b0;
            end
            return '{1'b0, last_x, last_y};
        end
        last_x = scale_pos(item.x_raw);
        last_y = scale_pos(item.y_raw);
        panel_pressed = 1'b1;
        return '{1'b1, last_x, last_y};
    endfunction

    // Idle lengths: mostly short, now and then a long stretch.
    function automatic int rand_gap();
        if ($urandom_range(99, 0) < 85) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic t_touch_item item_of(logic op, logic irq, int z1, int z2, int x, int y);
        t_touch_item item;
        item.opcode = op;
        item.irq_released = irq;
        item.z1_raw = AW'(z1);
        item.z2_raw = AW'(z2);
        item.x_raw = AW'(x);
        item.y_raw = AW'(y);
        return item;
    endfunction

    function automatic t_touch_item make_noise();
        return item_of(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                       $urandom_range(4095, 0), $urandom_range(4095, 0),
                       $urandom_range(4095, 0), $urandom_range(4095, 0));
    endfunction

    function automatic t_touch_item make_consume();
        t_touch_item item;
        item = make_noise();
        item.opcode = rtq_pkg::OP_CONSUME;
        return item;
    endfunction

    // A sample that, under the current settings, reads as a touch or a release.
    function automatic t_touch_item make_sample(bit press);
        t_touch_item item;
        int          pressure;
        int          z1_lo;
        int          z1_hi;
        item = make_noise();
        item.opcode = rtq_pkg::OP_SAMPLE;
        if (press) begin
            if (cfg_irq_used) item.irq_released = 1'b0;
            pressure = $urandom_range(MAX_PRESSURE, cfg_threshold);
        end else if (cfg_irq_used && ($urandom_range(1, 0) == 1 || cfg_threshold == 0)) begin
            item.irq_released = 1'b1;
            pressure = $urandom_range(MAX_PRESSURE, 0);
        end else begin
            if (cfg_irq_used) item.irq_released = 1'b0;
            if (cfg_threshold == 0) begin
                pressure = $urandom_range(MAX_PRESSURE, 0);
            end else begin
                pressure = $urandom_range(int'(cfg_threshold) - 1, 0);
            end
        end
        // Split the pressure into a legal pair of Z readings.
        z1_lo = (pressure > 4095) ? pressure - 4095 : 0;
        z1_hi = (pressure < 4095) ? pressure : 4095;
        item.z1_raw = AW'($urandom_range(z1_hi, z1_lo));
        item.z2_raw = AW'(int'(item.z1_raw) + 4095 - pressure);
        return item;
    endfunction

    // Offer one item, wait for the handshake and queue its expected report.
    task automatic send_touch(t_touch_item item);
        int gap;
        gap = (!src_steady && $urandom_range(99, 0) < 35) ? rand_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.opcode <= item.opcode;
        in_if.irq_released <= item.irq_released;
        in_if.z1_raw <= item.z1_raw;
        in_if.z2_raw <= item.z2_raw;
        in_if.x_raw <= item.x_raw;
        in_if.y_raw <= item.y_raw;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_reports.push_back(predict_report(item));
    endtask

    // Stop sending and let every outstanding report come back.
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            rtq_pkg::REG_ARMED:     cfg_armed = value[0];
            rtq_pkg::REG_IRQ_USED:  cfg_irq_used = value[0];
            rtq_pkg::REG_THRESHOLD: cfg_threshold = value[PRW-1:0];
            rtq_pkg::REG_CAL_MIN:   cfg_cal_min = value[AW-1:0];
            rtq_pkg::REG_CAL_MAX:   cfg_cal_max = value[AW-1:0];
            rtq_pkg::REG_OUT_MAX:   cfg_out_max = value[AW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int armed, int irq_used, int threshold, int cal_min,
                              int cal_max, int out_max);
        wait_drained();
        apb_write(rtq_pkg::REG_ARMED, armed);
        apb_write(rtq_pkg::REG_IRQ_USED, irq_used);
        apb_write(rtq_pkg::REG_THRESHOLD, threshold);
        apb_write(rtq_pkg::REG_CAL_MIN, cal_min);
        apb_write(rtq_pkg::REG_CAL_MAX, cal_max);
        apb_write(rtq_pkg::REG_OUT_MAX, out_max);
    endtask

    task automatic set_random_config(int armed, bit ordered);
        int a;
        int b;
        a = $urandom_range(4095, 0);
        b = $urandom_range(4095, 0);
        if (ordered && a > b) begin
            a = a ^ b;
            b = a ^ b;
            a = a ^ b;
        end
        set_config(armed, $urandom_range(1, 0), $urandom_range(MAX_PRESSURE, 0), a, b,
                   $urandom_range(4095, 1));
    endtask

    // Mostly touch strokes (presses, a release, often a consume), some noise.
    task automatic run_touch_traffic(int n_items);
        int sent;
        int presses;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99, 0) < 10) src_steady = !src_steady;
            if ($urandom_range(99, 0) < 10) sink_steady = !sink_steady;
            if ($urandom_range(99, 0) < 75) begin
                presses = $urandom_range(6, 1);
                repeat (presses) begin
                    send_touch(make_sample(1'b1));
                    sent++;
                end
                send_touch(make_sample(1'b0));
                sent++;
                if ($urandom_range(99, 0) < 70) begin
                    send_touch(make_consume());
                    sent++;
                end
            end else begin
                send_touch(make_noise());
                sent++;
            end
        end
        src_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Out of reset the block is not armed.
    task automatic test_not_armed();
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 4095, 0, 2000, 2000));
        send_touch(item_of(rtq_pkg::OP_CONSUME, 1'b1, 4095, 4095, 4095, 4095));
    endtask

    task automatic test_directed_touch();
        set_config(1, 1, rtq_pkg::RST_THRESHOLD, rtq_pkg::RST_CAL_MIN, rtq_pkg::RST_CAL_MAX,
                   rtq_pkg::RST_OUT_MAX);
        // Presses with both clamps, then pressure exactly at the threshold.
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 4095, 0, 0, 4095));
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 2000, 2000, 4095, 0));
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 0, 3695, 1234, 2345));
        // Pressure one below the threshold releases and latches a tap.
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 0, 3696, 100, 200));
        // A release while not pressed latches nothing new.
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 0, 4095, 4095, 4095));
        send_touch(item_of(rtq_pkg::OP_CONSUME, 1'b0, 0, 0, 0, 0));
        send_touch(item_of(rtq_pkg::OP_CONSUME, 1'b0, 0, 0, 0, 0));
        // Release through the pen-interrupt line despite full pressure.
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 3000, 100, 3000, 600));
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b1, 4095, 0, 3000, 600));
        send_touch(item_of(rtq_pkg::OP_CONSUME, 1'b1, 4095, 4095, 4095, 4095));

        // Interrupt line ignored, zero threshold, full-range window.
        set_config(1, 0, 0, 0, 4095, 4095);
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b1, 0, 4095, 4095, 0));
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 1, 4095, 2048, 1));

        // Empty window with the highest threshold.
        set_config(1, 1, MAX_PRESSURE, 2000, 2000, rtq_pkg::RST_OUT_MAX);
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 4095, 0, 2500, 1500));
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 4095, 1, 2500, 1500));
        send_touch(item_of(rtq_pkg::OP_CONSUME, 1'b0, 0, 0, 0, 0));

        // Inverted window, then a zero output range.
        set_config(1, 1, rtq_pkg::RST_THRESHOLD, 4095, 0, 1);
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 3000, 1000, 4095, 0));
        set_config(1, 1, rtq_pkg::RST_THRESHOLD, rtq_pkg::RST_CAL_MIN, rtq_pkg::RST_CAL_MAX, 0);
        send_touch(item_of(rtq_pkg::OP_SAMPLE, 1'b0, 3000, 1000, 2000, 3000));
    endtask

    // Hold the receiver off while items keep coming, then pause the sender.
    task automatic test_backpressure();
        set_config(1, 1, rtq_pkg::RST_THRESHOLD, rtq_pkg::RST_CAL_MIN, rtq_pkg::RST_CAL_MAX,
                   rtq_pkg::RST_OUT_MAX);
        sink_hold_req = 300;
        src_steady = 1'b1;
        repeat (12) send_touch(make_sample($urandom_range(1, 0) == 1));
        src_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        set_config(1, 1, rtq_pkg::RST_THRESHOLD, rtq_pkg::RST_CAL_MIN, rtq_pkg::RST_CAL_MAX,
                   rtq_pkg::RST_OUT_MAX);
        run_touch_traffic(180);
        set_config(1, 0, 0, 0, 4095, 4095);
        run_touch_traffic(160);
        set_config(1, 1, MAX_PRESSURE, 0, 4095, 1);
        run_touch_traffic(140);
        set_random_config(1, 1'b1);
        run_touch_traffic(170);
        set_random_config(1, 1'b0);
        run_touch_traffic(160);
        set_random_config(0, 1'b1);
        run_touch_traffic(80);
        set_random_config(1, 1'b1);
        run_touch_traffic(110);
    endtask

    // Receiver: long hold-offs on request, random stalls otherwise.
    always @(negedge i_clk) begin
        if (sink_hold_req > 0) begin
            out_if.ready <= 1'b0;
            sink_hold_req <= sink_hold_req - 1;
        end else if (sink_gap > 0) begin
            out_if.ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (!sink_steady && $urandom_range(99, 0) < 20) begin
            out_if.ready <= 1'b0;
            sink_gap <= rand_gap() - 1;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Compare every accepted result item with the oldest expected report.
    always @(posedge i_clk) begin
        t_touch_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result item: flag %0d x_pos %0d y_pos %0d",
                       out_if.flag, $signed(out_if.x_pos), $signed(out_if.y_pos));
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (out_if.flag !== want.flag) begin
                    $error("flag: expected %0d, got %0d", want.flag, out_if.flag);
                    error_count++;
                end
                if (out_if.x_pos !== want.x_pos) begin
                    $error("x_pos: expected %0d, got %0d",
                           $signed(want.x_pos), $signed(out_if.x_pos));
                    error_count++;
                end
                if (out_if.y_pos !== want.y_pos) begin
                    $error("y_pos: expected %0d, got %0d",
                           $signed(want.y_pos), $signed(out_if.y_pos));
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge i_clk);
        $display("Timeout after %0d cycles", cycles);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.opcode = rtq_pkg::OP_SAMPLE;
        in_if.irq_released = 1'b0;
        in_if.z1_raw = '0;
        in_if.z2_raw = '0;
        in_if.x_raw = '0;
        in_if.y_raw = '0;
        out_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        error_count = 0;
        sink_hold_req = 0;
        sink_gap = 0;
        sink_steady = 1'b0;
        src_steady = 1'b0;

        cfg_armed = rtq_pkg::RST_ARMED;
        cfg_irq_used = rtq_pkg::RST_IRQ_USED;
        cfg_threshold = rtq_pkg::RST_THRESHOLD;
        cfg_cal_min = rtq_pkg::RST_CAL_MIN;
        cfg_cal_max = rtq_pkg::RST_CAL_MAX;
        cfg_out_max = rtq_pkg::RST_OUT_MAX;
        panel_pressed = 1'b0;
        tap_latched = 1'b0;
        last_x = rtq_pkg::NONE_POS;
        last_y = rtq_pkg::NONE_POS;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_not_armed();
        test_directed_touch();
        test_backpressure();
        test_random_traffic();
        wait_drained();

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rtq_pkg.sv
sv/rtq_in_if.sv
sv/rtq_out_if.sv
sv/resistive_touch_qualifier.sv
sim/tb.sv
